>>> hw/rtl/aci_pkg.sv
// Package for the automation curve interpolator: sizes, item modes, curve kinds.
// Used by automation_curve_interpolator and its testbench.
package aci_pkg;
	localparam int TracksDef = 8;
	localparam int PointsDef = 16;
	localparam int BusesDef  = 4;
	localparam int KINDS     = 3;
	localparam logic [31:0] ONE_Q = 32'sd65536;

	typedef enum logic [1:0] {
		MODE_POINT  = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_GAIN = 2'd0;
	localparam logic [1:0] KIND_PAN  = 2'd1;
	localparam logic [1:0] KIND_BUS  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;
endpackage

>>> hw/rtl/aci_divider.sv
// Restoring divider for the interpolation factor: 49-bit numerator / 33-bit divisor.
// One quotient bit per cycle. Depends on nothing outside this file.
module aci_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [48:0] quo
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [48:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [33:0] trial;
	logic [33:0] shifted;

	assign shifted = {rem_q[32:0], quo_q[48]};
	assign trial   = shifted - {1'b0, den_q};

	// Shift one numerator bit in per cycle, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial;
				end else begin
					rem_q <= shifted;
				end
				quo_q <= {quo_q[47:0], ~trial[33]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = quo_q;
endmodule

>>> hw/rtl/automation_curve_interpolator.sv
// Automation curve interpolator: per-track breakpoint curves, queried at a beat.
// A query's duration is set by the one-port point memory read per search probe
// and the bit-serial divider. One item at a time. Reset clears tracks_in_use and
// the curve headers (empty, linear, default zero); point memories hold garbage
// until written.
module automation_curve_interpolator #(
	parameter int TRACKS = aci_pkg::TracksDef,
	parameter int POINTS = aci_pkg::PointsDef,
	parameter int BUSES  = aci_pkg::BusesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  track,
	input  logic [1:0]  kind,
	input  logic [3:0]  point_index,
	input  logic [4:0]  point_count,
	input  logic        step_mode,
	input  logic signed [31:0] beat,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] result_value
);
	localparam int CURVES = TRACKS * aci_pkg::KINDS;
	localparam int CW = (CURVES > 1) ? $clog2(CURVES) : 1;
	localparam int PW = $clog2(POINTS);
	localparam int NW = PW + 1;
	localparam int AW = CW + PW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEARCH, ST_PROBE, ST_RDA, ST_RDB, ST_WAITB, ST_DIV, ST_DIVW,
		ST_MUL, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [3:0]  tiu_q;
	logic [31:0] beat_mem [CURVES*(2**PW)];
	logic [31:0] val_mem  [CURVES*(2**PW)];
	logic [NW-1:0] cnt_q  [CURVES];
	logic          step_q [CURVES];
	logic [31:0]   def_q  [CURVES];

	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_beat, rd_val;

	logic [CW-1:0] cur_q;
	logic [1:0]  kind_q;
	logic signed [31:0] qbeat_q;
	logic [NW-1:0] lo_q, len_q, n_q;
	logic [NW-1:0] mid;
	logic signed [31:0] a_q, va_q, b_q, vb_q;
	logic signed [63:0] r_q;
	logic signed [31:0] res_q;
	logic        out_valid_q;
	logic        div_start, div_done;
	logic [48:0] div_num, div_quo;
	logic [32:0] div_den;
	logic signed [32:0] mul_dv;
	logic [16:0] mul_t;
	logic signed [50:0] mul_p;

	logic [5:0]  t_track;
	logic [CW+1:0] t_cur;
	logic        wr_ok, accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign t_track  = {2'b0, track};
	assign t_cur    = (CW+2)'(track) * (CW+2)'(3) + (CW+2)'(kind);
	assign wr_ok    = (32'(track) < TRACKS) && (kind != aci_pkg::KIND_NONE);
	assign mid      = lo_q + (len_q >> 1);

	// Point memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && mode == aci_pkg::MODE_POINT && wr_ok && 32'(point_index) < POINTS) begin
			beat_mem[{t_cur[CW-1:0], point_index[PW-1:0]}] <= beat;
			val_mem[{t_cur[CW-1:0], point_index[PW-1:0]}]  <= value;
		end
		if (rd_en) begin
			rd_beat <= beat_mem[rd_addr];
			rd_val  <= val_mem[rd_addr];
		end
	end

	// Curve headers and tracks_in_use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiu_q <= '0;
			for (int i = 0; i < CURVES; i++) begin
				cnt_q[i]  <= '0;
				step_q[i] <= 1'b0;
				def_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				tiu_q <= cfg_wdata;
			end
			if (accept && mode == aci_pkg::MODE_HEADER && wr_ok) begin
				cnt_q[t_cur[CW-1:0]]  <= (32'(point_count) > POINTS) ? NW'(POINTS)
					: NW'(point_count);
				step_q[t_cur[CW-1:0]] <= step_mode;
				def_q[t_cur[CW-1:0]]  <= value;
			end
		end
	end

	// Read address per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {cur_q, mid[PW-1:0]};
		case (state_q)
			ST_SEARCH: rd_en = (len_q != '0);
			ST_RDA: begin
				rd_en = 1'b1;
				if (lo_q == '0) begin
					rd_addr = {cur_q, {PW{1'b0}}};
				end else if (lo_q >= n_q) begin
					rd_addr = {cur_q, PW'(n_q - NW'(1))};
				end else begin
					rd_addr = {cur_q, PW'(lo_q - NW'(1))};
				end
			end
			ST_RDB: begin
				rd_en   = 1'b1;
				rd_addr = {cur_q, lo_q[PW-1:0]};
			end
			default: rd_en = 1'b0;
		endcase
	end

	assign div_start = (state_q == ST_DIV);
	assign div_num   = {1'b0, 48'(qbeat_q - a_q) << 16};
	assign div_den   = 33'(b_q) - 33'(a_q);

	aci_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// Value step times the factor clamped to 1.0
	assign mul_dv = 33'(vb_q) - 33'(va_q);
	assign mul_t  = (div_quo > 49'd65536) ? 17'd65536 : div_quo[16:0];
	assign mul_p  = mul_dv * $signed({1'b0, mul_t});

	// Final shaping by kind: clamp pan, round and clamp bus, pass gain through
	function automatic logic [31:0] finish(input logic [1:0] k, input logic signed [31:0] r);
		logic signed [31:0] b;
		begin
			b = 32'sd0;
			if (k == aci_pkg::KIND_PAN) begin
				b = (r < -32'sd65536) ? -32'sd65536 : (r > 32'sd65536) ? 32'sd65536 : r;
			end else if (k == aci_pkg::KIND_BUS) begin
				if (r < 32'sd0) begin
					b = 32'sd0;
				end else begin
					b = 32'(({1'b0, r} + 33'd32768) >> 16);
					if (b > 32'(BUSES - 1)) begin
						b = 32'(BUSES - 1);
					end
				end
			end else begin
				b = r;
			end
			finish = b;
		end
	endfunction

	// Sequencer: search, fetch neighbors, divide, multiply, clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && mode == aci_pkg::MODE_QUERY) begin
						cur_q   <= t_cur[CW-1:0];
						kind_q  <= kind;
						qbeat_q <= beat;
						lo_q    <= '0;
						if (kind == aci_pkg::KIND_NONE) begin
							res_q <= '0;
							state_q <= ST_OUT;
						end else if (t_track >= {2'b0, tiu_q} || 32'(track) >= TRACKS) begin
							res_q <= (kind == aci_pkg::KIND_BUS) ? 32'd1 : 32'd0;
							state_q <= ST_OUT;
						end else if (cnt_q[t_cur[CW-1:0]] == '0) begin
							res_q <= finish(kind, def_q[t_cur[CW-1:0]]);
							state_q <= ST_OUT;
						end else begin
							n_q     <= cnt_q[t_cur[CW-1:0]];
							len_q   <= cnt_q[t_cur[CW-1:0]];
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					state_q <= (len_q != '0) ? ST_PROBE : ST_RDA;
				end
				ST_PROBE: begin
					if ($signed(rd_beat) < qbeat_q) begin
						lo_q  <= mid + NW'(1);
						len_q <= len_q - (len_q >> 1) - NW'(1);
					end else begin
						len_q <= len_q >> 1;
					end
					state_q <= ST_SEARCH;
				end
				ST_RDA: begin
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					a_q  <= rd_beat;
					va_q <= rd_val;
					if (lo_q == '0 || lo_q >= n_q) begin
						res_q   <= finish(kind_q, rd_val);
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_WAITB;
					end
				end
				ST_WAITB: begin
					b_q  <= rd_beat;
					vb_q <= rd_val;
					if (step_q[cur_q] || $signed(rd_beat) <= a_q) begin
						res_q   <= finish(kind_q, va_q);
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						r_q     <= 64'(mul_p);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					res_q   <= finish(kind_q, 32'(64'(signed'(va_q)) + (r_q >>> 16)));
					state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						result_value <= res_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// A search probe never runs past the curve's point count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> lo_q + len_q <= n_q)
		else $error("search window beyond point count");
	// Input is held off while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> in_stall)
		else $error("input taken while result pending");
	// Divider only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider done outside wait state");
endmodule

>>> tb/tb_automation_curve_interpolator.sv
// Testbench for automation_curve_interpolator: drives write, header and query requests,
// predicts each answer from its own curve store and checks every result in order.
// Depends on aci_pkg and the automation_curve_interpolator RTL.
`timescale 1ns / 1ps

module tb_automation_curve_interpolator;

	localparam int NTRK = 8;
	localparam int NPTS = 16;
	localparam int NBUS = 4;
	localparam int NCRV = NTRK * aci_pkg::KINDS;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RAND_PER_PHASE = 180;

	typedef struct {
		aci_pkg::mode_t md;
		logic [3:0]  trk;
		logic [1:0]  knd;
		logic [3:0]  pidx;
		logic [4:0]  pcnt;
		logic        stp;
		logic signed [31:0] bt;
		logic signed [31:0] val;
		bit          drain;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [3:0] track = '0;
	logic [1:0] kind = '0;
	logic [3:0] point_index = '0;
	logic [4:0] point_count = '0;
	logic step_mode = 1'b0;
	logic signed [31:0] beat = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_value;

	// predicted curve store
	logic signed [31:0] pt_beat [NCRV*NPTS];
	logic signed [31:0] pt_val [NCRV*NPTS];
	int unsigned crv_cnt [NCRV];
	bit crv_step [NCRV];
	logic signed [31:0] crv_dflt [NCRV];
	logic [3:0] tracks_live = '0;

	request_t request_q[$];
	request_t cur_req;
	logic signed [31:0] answer_q[$];
	int snd_idle = 0;
	int rcv_idle = 0;
	int fail_count = 0;
	int req_count = 0;
	int answer_count = 0;
	int unsigned cycle_count = 0;

	automation_curve_interpolator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .track(track), .kind(kind), .point_index(point_index),
		.point_count(point_count), .step_mode(step_mode), .beat(beat), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .result_value(result_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint floor_div(longint num, longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// lower-bound search, then hold the end value or interpolate between neighbors
	function automatic longint curve_answer(int c, logic signed [31:0] bt);
		int n, lo, len, half, mid, base;
		longint a, b, va, vb, t;
		n = crv_cnt[c];
		base = c * NPTS;
		if (n == 0)
			return crv_dflt[c];
		lo = 0;
		len = n;
		while (len > 0) begin
			half = len / 2;
			mid = lo + half;
			if (pt_beat[base+mid] < bt) begin
				lo = mid + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		if (lo == 0)
			return pt_val[base];
		if (lo >= n)
			return pt_val[base+n-1];
		a = pt_beat[base+lo-1];
		b = pt_beat[base+lo];
		va = pt_val[base+lo-1];
		vb = pt_val[base+lo];
		if (crv_step[c] || b <= a)
			return va;
		t = floor_div((longint'(bt) - a) * 65536, b - a);
		if (t < 0) t = 0;
		if (t > 65536) t = 65536;
		return va + floor_div((vb - va) * t, 65536);
	endfunction

	// update the store on a write, queue the answer on a query
	task automatic apply_request(request_t r);
		int c;
		longint res;
		c = r.trk * aci_pkg::KINDS + r.knd;
		req_count++;
		case (r.md)
			aci_pkg::MODE_POINT: begin
				if (r.trk < NTRK && r.knd < aci_pkg::KINDS && r.pidx < NPTS) begin
					pt_beat[c*NPTS+r.pidx] = r.bt;
					pt_val[c*NPTS+r.pidx] = r.val;
				end
			end
			aci_pkg::MODE_HEADER: begin
				if (r.trk < NTRK && r.knd < aci_pkg::KINDS) begin
					crv_cnt[c] = (r.pcnt > NPTS) ? NPTS : r.pcnt;
					crv_step[c] = r.stp;
					crv_dflt[c] = r.val;
				end
			end
			aci_pkg::MODE_QUERY: begin
				if (r.knd == aci_pkg::KIND_NONE) begin
					res = 0;
				end else if (r.trk >= tracks_live || r.trk >= NTRK) begin
					res = (r.knd == aci_pkg::KIND_BUS) ? 1 : 0;
				end else begin
					res = curve_answer(c, r.bt);
					if (r.knd == aci_pkg::KIND_PAN) begin
						if (res < -65536) res = -65536;
						if (res > 65536) res = 65536;
					end else if (r.knd == aci_pkg::KIND_BUS) begin
						if (res >= 0) res = (res + 32768) / 65536;
						else res = -((-res + 32768) / 65536);
						if (res < 0) res = 0;
						if (res > NBUS - 1) res = NBUS - 1;
					end
				end
				answer_q.push_back(res[31:0]);
			end
			default: ;
		endcase
	endtask

	// driver: present the next request, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(cur_req);
			if (!in_valid || !in_stall) begin
				if (request_q.size() > 0 && $urandom_range(99) >= snd_idle &&
						!(request_q[0].drain && answer_q.size() > 0)) begin
					cur_req = request_q.pop_front();
					in_valid <= 1'b1;
					mode <= cur_req.md;
					track <= cur_req.trk;
					kind <= cur_req.knd;
					point_index <= cur_req.pidx;
					point_count <= cur_req.pcnt;
					step_mode <= cur_req.stp;
					beat <= cur_req.bt;
					value <= cur_req.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: stall at random, compare each answer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$error("result_value: no answer expected, actual %0d", result_value);
					fail_count++;
				end else begin
					if (result_value !== answer_q[0]) begin
						$error("result_value: expected %0d, actual %0d",
							answer_q[0], result_value);
						fail_count++;
					end
					void'(answer_q.pop_front());
					answer_count++;
				end
			end
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	function automatic void push_req(aci_pkg::mode_t md, int trk, int knd, int pidx,
			int pcnt, int stp, logic signed [31:0] bt, logic signed [31:0] val,
			bit drain = 0);
		request_t r;
		r.md = md;
		r.trk = 4'(trk);
		r.knd = 2'(knd);
		r.pidx = 4'(pidx);
		r.pcnt = 5'(pcnt);
		r.stp = 1'(stp);
		r.bt = bt;
		r.val = val;
		r.drain = drain;
		request_q.push_back(r);
	endfunction

	function automatic logic signed [31:0] rand_signed(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	// load one curve with mostly sorted points, then query it around its span
	function automatic int add_curve_sequence();
		int trk, knd, n, cnt, vspan, made;
		logic signed [31:0] bt, first_bt;
		trk = $urandom_range(NTRK - 1);
		knd = $urandom_range(aci_pkg::KINDS - 1);
		n = ($urandom_range(3) == 0) ? $urandom_range(NPTS) : $urandom_range(1, 5);
		vspan = (knd == aci_pkg::KIND_GAIN) ? (1 << 22) :
			(knd == aci_pkg::KIND_PAN) ? (3 << 16) : (6 << 16);
		bt = rand_signed(1 << 22);
		first_bt = bt;
		made = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				push_req(aci_pkg::MODE_POINT, trk, knd, i, 0, 0, $urandom(), $urandom());
			else
				push_req(aci_pkg::MODE_POINT, trk, knd, i, 0, 0, bt,
					($urandom_range(15) == 0) ? $urandom() : rand_signed(vspan));
			bt = bt + (($urandom_range(4) == 0) ? 0 : $urandom_range(1 << 18));
			made++;
		end
		cnt = (n <= 15 && $urandom_range(7) == 0) ? n + 16 : n;
		push_req(aci_pkg::MODE_HEADER, trk, knd, 0, cnt, $urandom_range(1), 0,
			rand_signed(vspan));
		made++;
		for (int q = $urandom_range(2, 6); q > 0; q--) begin
			push_req(aci_pkg::MODE_QUERY, trk, knd, 0, 0, 0,
				($urandom_range(9) == 0) ? $urandom() :
				first_bt - (1 << 17) + $urandom_range(bt - first_bt + (1 << 18)), 0);
			made++;
		end
		return made;
	endfunction

	// mostly curve sequences, the rest raw items with every field at random
	task automatic fill_random(int target, bit with_drain);
		int made;
		made = 0;
		while (made < target) begin
			if ($urandom_range(4) != 0) begin
				made += add_curve_sequence();
			end else begin
				push_req(aci_pkg::mode_t'(2'($urandom_range(3))), $urandom_range(15),
					$urandom_range(3), $urandom_range(15), $urandom_range(31),
					$urandom_range(1), $urandom(), $urandom(),
					with_drain && $urandom_range(30) == 0);
				made++;
			end
		end
	endtask

	task automatic wait_idle();
		while (request_q.size() > 0 || in_valid || answer_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tracks(int n);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 4'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracks_live = 4'(n);
	endtask

	task automatic run_phase(int tracks, int s_idle, int r_idle, bit with_drain);
		wait_idle();
		write_tracks(tracks);
		snd_idle = s_idle;
		rcv_idle = r_idle;
		fill_random(RAND_PER_PHASE, with_drain);
	endtask

	initial begin
		for (int i = 0; i < NCRV; i++) begin
			crv_cnt[i] = 0;
			crv_step[i] = 0;
			crv_dflt[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_tracks(8);

		// write every point slot once so no query reaches an unwritten entry
		for (int c = 0; c < NCRV; c++)
			for (int p = 0; p < NPTS; p++)
				push_req(aci_pkg::MODE_POINT, c / aci_pkg::KINDS, c % aci_pkg::KINDS, p,
					0, 0, p << 16, $urandom());

		// empty curves answer the default, clamped per kind
		push_req(aci_pkg::MODE_HEADER, 0, aci_pkg::KIND_PAN, 0, 0, 0, 0, 32'sh7FFF_FFFF);
		push_req(aci_pkg::MODE_QUERY, 0, aci_pkg::KIND_PAN, 0, 0, 0, 0, 0);
		push_req(aci_pkg::MODE_HEADER, 0, aci_pkg::KIND_BUS, 0, 0, 0, 0, 32'sh0001_8000);
		push_req(aci_pkg::MODE_QUERY, 0, aci_pkg::KIND_BUS, 0, 0, 0, 0, 0);
		push_req(aci_pkg::MODE_HEADER, 1, aci_pkg::KIND_BUS, 0, 0, 0, 0, 32'sh8000_0000);
		push_req(aci_pkg::MODE_QUERY, 1, aci_pkg::KIND_BUS, 0, 0, 0, 32'sh7FFF_FFFF, 0);
		// gain curve: before first, between, past last, equal beats
		push_req(aci_pkg::MODE_POINT, 2, aci_pkg::KIND_GAIN, 0, 0, 0, 32'sh0001_0000,
			32'sh8000_0000);
		push_req(aci_pkg::MODE_POINT, 2, aci_pkg::KIND_GAIN, 1, 0, 0, 32'sh0003_0000,
			32'sh7FFF_FFFF);
		push_req(aci_pkg::MODE_POINT, 2, aci_pkg::KIND_GAIN, 2, 0, 0, 32'sh0003_0000,
			32'sh0000_1234);
		push_req(aci_pkg::MODE_HEADER, 2, aci_pkg::KIND_GAIN, 0, 3, 0, 0, 0);
		push_req(aci_pkg::MODE_QUERY, 2, aci_pkg::KIND_GAIN, 0, 0, 0, 32'sh8000_0000, 0);
		push_req(aci_pkg::MODE_QUERY, 2, aci_pkg::KIND_GAIN, 0, 0, 0, 32'sh0002_8001, 0);
		push_req(aci_pkg::MODE_QUERY, 2, aci_pkg::KIND_GAIN, 0, 0, 0, 32'sh7FFF_FFFF, 0);
		// step mode, oversized count, bad kind and bad mode, write out of range
		push_req(aci_pkg::MODE_HEADER, 2, aci_pkg::KIND_GAIN, 0, 31, 1, 0, 0);
		push_req(aci_pkg::MODE_QUERY, 2, aci_pkg::KIND_GAIN, 0, 0, 0, 32'sh0002_0000, 0);
		push_req(aci_pkg::MODE_QUERY, 3, aci_pkg::KIND_NONE, 0, 0, 0, 0, 0);
		push_req(aci_pkg::MODE_HEADER, 3, aci_pkg::KIND_NONE, 0, 5, 1, 0, 1);
		push_req(aci_pkg::MODE_NONE, 15, aci_pkg::KIND_NONE, 15, 31, 1, 32'shFFFF_FFFF,
			32'shFFFF_FFFF);
		push_req(aci_pkg::MODE_HEADER, 12, aci_pkg::KIND_GAIN, 0, 2, 0, 0, 5);
		push_req(aci_pkg::MODE_QUERY, 12, aci_pkg::KIND_BUS, 0, 0, 0, 0, 0);
		push_req(aci_pkg::MODE_QUERY, 7, aci_pkg::KIND_PAN, 0, 0, 0, 32'sh0000_8000, 0, 1);
		fill_random(RAND_PER_PHASE / 2, 0);

		run_phase(0, 69, 0, 0);
		run_phase(15, 0, 69, 0);
		run_phase(5, 27, 27, 1);
		run_phase(8, 0, 0, 0);

		wait_idle();
		$display("Covered %0d requests and %0d checked answers over five track settings,",
			req_count, answer_count);
		$display("with sender gaps, receiver stalls and a pause for results to drain.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
